// ===== rtl/dsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Descriptor slot allocator package
// Widths, codes, item types and sequencer states shared by the allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

	localparam int MAX_SLOTS = 4096;
	localparam int ADDR_W    = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	localparam int ADDR_BITS = 64;
	localparam int IDX_W     = 12;
	localparam int STRIDE_W  = 11;
	localparam int CAP_W     = 13;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam int DIV_BITS  = 5;
	localparam int DIV_STEPS = 13;
	localparam int WRK_W     = DIV_BITS * DIV_STEPS;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int PROD_W    = ADDR_W + STRIDE_W;

	localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);
	localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(4096);

	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_XLATE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [ADDR_BITS-1:0] cpu_address;
	} dsa_req_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] slot_cpu_address;
		logic [ADDR_BITS-1:0] slot_gpu_address;
		logic [IDX_W-1:0]     slot_index;
		logic [STATUS_W-1:0]  status;
	} dsa_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCALE,
		ST_BASE,
		ST_OFFSET,
		ST_DIVIDE,
		ST_PUSH,
		ST_ADJUST,
		ST_GPU,
		ST_FINISH
	} dsa_state_t;

endpackage
`default_nettype wire

// ===== rtl/dsa_div_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Divider step
// Retires a few quotient bits of a restoring division by the slot stride.
// ----------------------------------------------------------------------------
module dsa_div_step import dsa_pkg::*; (
	input  wire logic [STRIDE_W-1:0] rem_in,
	input  wire logic [STRIDE_W-1:0] divisor,
	input  wire logic [DIV_BITS-1:0] chunk,
	output logic      [STRIDE_W-1:0] rem_out,
	output logic      [DIV_BITS-1:0] qbits
);

	always_comb begin
		logic [STRIDE_W:0]   t;
		logic [STRIDE_W-1:0] r;
		r     = rem_in;
		qbits = '0;
		for (int i = DIV_BITS - 1; i >= 0; i--) begin
			t = {r, chunk[i]};
			if (t >= {1'b0, divisor}) begin
				t        = t - {1'b0, divisor};
				qbits[i] = 1'b1;
			end
			r = t[STRIDE_W-1:0];
		end
		rem_out = r;
	end

endmodule
`default_nettype wire

// ===== rtl/descriptor_slot_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Descriptor slot allocator
// Free-list stack allocator for fixed-size descriptor slots in a heap.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel and each gives one item on the rsp
// channel, both valid/ready. Mode allocate pops the free stack or takes the
// next unused index; free divides the address offset by the stride and
// pushes the index; translate maps a CPU address to its GPU address.
// The block takes one request at a time. Allocate passes through the scale,
// base and finish states; a full heap or an unused mode goes straight to
// finish. Free and translate divide the offset by the stride five quotient
// bits per cycle, and one shared 64-bit adder forms the offset and the final
// addresses in separate cycles. The response sits in an output register, so
// a new request is accepted while a finished item still waits; a stalled
// receiver only holds up the finish state of the following request. The
// user must write registers through the cfg port only while the block is
// idle; the block itself does not enforce this. Reset empties the free stack
// and the unused index at once; the stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator import dsa_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire dsa_req_t             req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output dsa_rsp_t                  rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADDR_BITS-1:0] cfg_data
);

	dsa_state_t state_q, state_d;

	logic [ADDR_BITS-1:0] cfg_cpu_base_q;
	logic [ADDR_BITS-1:0] cfg_gpu_base_q;
	logic [STRIDE_W-1:0]  cfg_stride_q;
	logic [CAP_W-1:0]     cfg_capacity_q;

	logic [CNT_W-1:0]  free_count_q;
	logic [CNT_W-1:0]  next_unused_q;
	logic [STEP_W-1:0] cnt_q;
	logic              pop_q;
	logic              rsp_valid_q;

	logic [ADDR_BITS-1:0] addr_q;
	logic [MODE_W-1:0]    mode_q;
	logic [ADDR_BITS-1:0] off_q;
	logic [WRK_W-1:0]     wrk_q;
	logic [STRIDE_W-1:0]  rem_q;
	logic [ADDR_W-1:0]    idx_q;
	logic [ADDR_W-1:0]    rd_q;
	logic [PROD_W-1:0]    prod_q;
	dsa_rsp_t             res_q;
	dsa_rsp_t             rsp_q;

	logic [ADDR_W-1:0] stack_mem [MAX_SLOTS];

	logic                 accept;
	logic                 stack_empty;
	logic                 can_alloc;
	logic                 stride_zero;
	logic                 q_over;
	logic                 push_drop;
	logic                 push_en;
	logic                 pop_en;
	logic                 out_load;
	logic [CNT_W-1:0]     pop_cnt;
	logic [ADDR_W-1:0]    pop_addr;
	logic [ADDR_W-1:0]    q_entry;
	logic [IDX_W-1:0]     q_idx;
	logic [ADDR_W-1:0]    idx_sel;
	logic [ADDR_BITS-1:0] add_a;
	logic [ADDR_BITS-1:0] add_b;
	logic                 add_sub;
	logic [ADDR_BITS-1:0] sum;
	logic [STRIDE_W-1:0]  rem_next;
	logic [DIV_BITS-1:0]  qbits;

	assign accept      = req_valid && req_ready;
	assign stack_empty = (free_count_q == '0);
	assign can_alloc   = (32'(next_unused_q) < 32'(cfg_capacity_q)) &&
	                     (32'(next_unused_q) < 32'(MAX_SLOTS));
	assign stride_zero = (cfg_stride_q == '0);
	assign q_over      = !stride_zero && (wrk_q >= WRK_W'(MAX_SLOTS));
	assign push_drop   = q_over || (free_count_q >= CNT_W'(MAX_SLOTS));
	assign q_entry     = stride_zero ? '0 : wrk_q[ADDR_W-1:0];
	assign q_idx       = stride_zero ? '0 : wrk_q[IDX_W-1:0];
	assign pop_cnt     = free_count_q - CNT_W'(1);
	assign pop_addr    = pop_cnt[ADDR_W-1:0];
	assign pop_en      = accept && (req.mode == MODE_ALLOC) && !stack_empty;
	assign idx_sel     = pop_q ? rd_q : idx_q;
	assign sum         = add_a + (add_sub ? ~add_b : add_b) + ADDR_BITS'(add_sub);

	dsa_div_step u_div_step (
		.rem_in  (rem_q),
		.divisor (cfg_stride_q),
		.chunk   (wrk_q[WRK_W-1 -: DIV_BITS]),
		.rem_out (rem_next),
		.qbits   (qbits)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.mode == MODE_ALLOC) begin
						state_d = (!stack_empty || can_alloc) ? ST_SCALE : ST_FINISH;
					end else if (req.mode == MODE_FREE || req.mode == MODE_XLATE) begin
						state_d = ST_OFFSET;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCALE:  state_d = ST_BASE;
			ST_BASE:   state_d = ST_FINISH;
			ST_OFFSET: state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = (mode_q == MODE_FREE) ? ST_PUSH : ST_ADJUST;
				end
			end
			ST_PUSH:   state_d = ST_FINISH;
			ST_ADJUST: state_d = ST_GPU;
			ST_GPU:    state_d = ST_FINISH;
			ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		out_load  = 1'b0;
		push_en   = 1'b0;
		add_a     = cfg_cpu_base_q;
		add_b     = ADDR_BITS'(prod_q);
		add_sub   = 1'b0;
		unique case (state_q)
			ST_IDLE:   req_ready = 1'b1;
			ST_OFFSET: begin
				add_a   = addr_q;
				add_b   = cfg_cpu_base_q;
				add_sub = 1'b1;
			end
			ST_ADJUST: begin
				add_a   = off_q;
				add_b   = stride_zero ? off_q : ADDR_BITS'(rem_q);
				add_sub = 1'b1;
			end
			ST_GPU: begin
				add_a = cfg_gpu_base_q;
				add_b = off_q;
			end
			ST_PUSH:   push_en  = !push_drop;
			ST_FINISH: out_load = !rsp_valid_q || rsp_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cfg_cpu_base_q <= '0;
			cfg_gpu_base_q <= '0;
			cfg_stride_q   <= STRIDE_RESET;
			cfg_capacity_q <= CAP_RESET;
			free_count_q   <= '0;
			next_unused_q  <= '0;
			cnt_q          <= '0;
			pop_q          <= 1'b0;
			rsp_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CPU_BASE: cfg_cpu_base_q <= cfg_data;
					REG_GPU_BASE: cfg_gpu_base_q <= cfg_data;
					REG_STRIDE:   cfg_stride_q   <= cfg_data[STRIDE_W-1:0];
					REG_CAPACITY: cfg_capacity_q <= cfg_data[CAP_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept && req.mode == MODE_ALLOC) begin
				pop_q <= !stack_empty;
				if (!stack_empty) begin
					free_count_q <= pop_cnt;
				end else if (can_alloc) begin
					next_unused_q <= next_unused_q + CNT_W'(1);
				end
			end
			if (push_en) begin
				free_count_q <= free_count_q + CNT_W'(1);
			end
			if (state_q == ST_DIVIDE) begin
				cnt_q <= (cnt_q == STEP_W'(DIV_STEPS - 1)) ? '0 : cnt_q + STEP_W'(1);
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[free_count_q[ADDR_W-1:0]] <= q_entry;
		end
		if (pop_en) begin
			rd_q <= stack_mem[pop_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= res_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					addr_q <= req.cpu_address;
					mode_q <= req.mode;
					idx_q  <= next_unused_q[ADDR_W-1:0];
					res_q  <= '{slot_cpu_address: '0, slot_gpu_address: '0, slot_index: '0,
						status: (req.mode == MODE_ALLOC && stack_empty && !can_alloc) ?
							STATUS_FULL : STATUS_OK};
				end
			end
			ST_SCALE: begin
				prod_q           <= PROD_W'(idx_sel) * PROD_W'(cfg_stride_q);
				res_q.slot_index <= IDX_W'(idx_sel);
			end
			ST_BASE: res_q.slot_cpu_address <= sum;
			ST_OFFSET: begin
				off_q <= sum;
				wrk_q <= WRK_W'(sum);
				rem_q <= '0;
			end
			ST_DIVIDE: begin
				wrk_q <= {wrk_q[WRK_W-DIV_BITS-1:0], qbits};
				rem_q <= rem_next;
			end
			ST_PUSH: begin
				res_q.slot_index <= q_idx;
				if (push_drop) begin
					res_q.status <= STATUS_OVERFLOW;
				end
			end
			ST_ADJUST: begin
				off_q            <= sum;
				res_q.slot_index <= q_idx;
			end
			ST_GPU: res_q.slot_gpu_address <= sum;
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_count_q <= CNT_W'(MAX_SLOTS))
		else $error("free stack count beyond its depth");

	a_unused_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_unused_q <= CNT_W'(MAX_SLOTS))
		else $error("unused index beyond the slot range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("request taken while the previous one is in flight");

	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		(free_count_q > $past(free_count_q)) |-> ($past(state_q) == ST_PUSH))
		else $error("free stack grew outside a push");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIVIDE) |-> (cnt_q == '0))
		else $error("divider step count left running");

endmodule
`default_nettype wire
